>>> design/psu_pkg.sv
// psu_pkg: shared types and codes for the PNG scanline unfilter unit.
// No dependencies; imported by psu_ctrl, psu_recon and the top level.
`default_nettype none

package psu_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 15;
  localparam int ROW_W      = 16;
  localparam int FILT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWC = 2'd2;

  // filter type codes
  localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
  localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
  localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
  localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
  localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

  // work passed from the sequencer to the reconstruction stage
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_ERROR  = 2'd2
  } psu_kind_t;

  typedef struct packed {
    psu_kind_t          kind;
    logic [FILT_W-1:0]  filt;
    logic [BYTE_W-1:0]  data;
    logic [1:0]         left_sel;
    logic               zero_above;
    logic               row_end;
    logic               image_end;
  } psu_op_t;

endpackage

`default_nettype wire

>>> design/psu_channels.sv
// psu_channels: valid/ready channel interfaces for input, result and config.
// Depends on psu_pkg for field widths.
`default_nettype none

interface psu_in_if;
  import psu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface psu_out_if;
  import psu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              row_end;
  logic              image_end;
  logic              bad_filter;
  modport source (output valid, output out_byte, output row_end, output image_end,
                  output bad_filter, input ready);
  modport sink   (input valid, input out_byte, input row_end, input image_end,
                  input bad_filter, output ready);
endinterface

interface psu_cfg_if;
  import psu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> design/psu_ram.sv
// psu_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/psu_ctrl.sv
// psu_ctrl: config registers and row/byte sequencer; turns each accepted byte
// outside a dropped span into a reconstruction op and a line-store read address. Depends on psu_pkg.
`default_nettype none

module psu_ctrl
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 16384,
  localparam int ADDR_W = $clog2(MAX_ROW_BYTES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_acc,
  input  wire logic [BYTE_W-1:0]     in_byte,
  output logic                       op_valid,
  output psu_op_t                    op,
  output logic      [ADDR_W-1:0]     op_idx
);

  localparam int RBW = 17;
  localparam logic [RBW-1:0] MAXV = RBW'(MAX_ROW_BYTES);

  localparam logic [1:0] PH_FILTER  = 2'd0;
  localparam logic [1:0] PH_SAMPLES = 2'd1;
  localparam logic [1:0] PH_DROP    = 2'd2;

  logic [2:0]        bpp_r;
  logic [POS_W-1:0]  rowb_r;
  logic [ROW_W-1:0]  rowc_r;
  logic [1:0]        phase_r, phase_nxt;
  logic [POS_W-1:0]  bp_r, bp_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [FILT_W-1:0] filt_r, filt_nxt;

  logic [RBW-1:0]    rb;
  logic [ROW_W-1:0]  rc;
  logic [2:0]        bpp_eff;
  logic              last_byte, drop_end, last_row;

  always_comb begin
    if (rowb_r == '0) begin
      rb = RBW'(1);
    end else if (RBW'(rowb_r) > MAXV) begin
      rb = MAXV;
    end else begin
      rb = RBW'(rowb_r);
    end
    rc = (rowc_r == '0) ? ROW_W'(1) : rowc_r;
    if (bpp_r == 3'd0) begin
      bpp_eff = 3'd1;
    end else if (bpp_r > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = bpp_r;
    end
    last_byte = (RBW'(bp_r) + RBW'(1)) >= rb;
    drop_end  = RBW'(bp_r) >= rb;
    last_row  = ({1'b0, row_r} + 17'd1) >= {1'b0, rc};
  end

  always_comb begin
    phase_nxt    = phase_r;
    bp_nxt       = bp_r;
    row_nxt      = row_r;
    filt_nxt     = filt_r;
    op_valid     = 1'b0;
    op.kind      = OP_CLEAR;
    op.filt      = filt_r;
    op.data      = in_byte;
    op.left_sel  = 2'(bpp_eff - 3'd1);
    op.zero_above = (row_r == '0);
    op.row_end   = 1'b0;
    op.image_end = 1'b0;
    if (in_acc) begin
      unique case (phase_r)
        PH_SAMPLES: begin
          op_valid     = 1'b1;
          op.kind      = OP_SAMPLE;
          op.row_end   = last_byte;
          op.image_end = last_byte && last_row;
          if (last_byte) begin
            bp_nxt    = '0;
            phase_nxt = PH_FILTER;
            row_nxt   = last_row ? '0 : row_r + ROW_W'(1);
          end else begin
            bp_nxt = bp_r + POS_W'(1);
          end
        end
        PH_DROP: begin
          if (drop_end) begin
            bp_nxt = '0;
            if (last_row) begin
              row_nxt   = '0;
              phase_nxt = PH_FILTER;
            end else begin
              row_nxt = row_r + ROW_W'(1);
            end
          end else begin
            bp_nxt = bp_r + POS_W'(1);
          end
        end
        default: begin
          op_valid = 1'b1;
          if (in_byte > BYTE_W'(FILT_PAETH)) begin
            op.kind   = OP_ERROR;
            bp_nxt    = POS_W'(1);
            phase_nxt = PH_DROP;
          end else begin
            op.kind   = OP_CLEAR;
            filt_nxt  = in_byte[FILT_W-1:0];
            bp_nxt    = '0;
            phase_nxt = PH_SAMPLES;
          end
        end
      endcase
    end
  end

  assign op_idx = ADDR_W'(bp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= 3'd4;
      rowb_r  <= POS_W'(4);
      rowc_r  <= ROW_W'(1);
      phase_r <= PH_FILTER;
      bp_r    <= '0;
      row_r   <= '0;
      filt_r  <= FILT_NONE;
    end else begin
      phase_r <= phase_nxt;
      bp_r    <= bp_nxt;
      row_r   <= row_nxt;
      filt_r  <= filt_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_BPP:  bpp_r  <= cfg_data[2:0];
          CFG_ROWB: rowb_r <= cfg_data[POS_W-1:0];
          CFG_ROWC: rowc_r <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> design/psu_recon.sv
// psu_recon: op register, neighbour histories, filter predictor and result
// register; writes reconstructed bytes back to the line store. Depends on psu_pkg.
`default_nettype none

module psu_recon
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 16384,
  localparam int ADDR_W = $clog2(MAX_ROW_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              op_valid,
  input  wire psu_op_t           op,
  input  wire logic [ADDR_W-1:0] op_idx,
  input  wire logic [BYTE_W-1:0] above_data,
  output logic                   take,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [BYTE_W-1:0] wr_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic      [BYTE_W-1:0] out_byte,
  output logic                   row_end,
  output logic                   image_end,
  output logic                   bad_filter
);

  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
    logic signed [10:0] sa, sb, sc, p, ta, tb, tc, da, db, dc;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    p  = sa + sb - sc;
    ta = p - sa;
    tb = p - sb;
    tc = p - sc;
    da = (ta < 0) ? -ta : ta;
    db = (tb < 0) ? -tb : tb;
    dc = (tc < 0) ? -tc : tc;
    if (da <= db && da <= dc) begin
      return a;
    end
    return (db <= dc) ? b : c;
  endfunction

  logic              a_valid_r;
  psu_op_t           a_op_r;
  logic [ADDR_W-1:0] a_idx_r;
  logic [31:0]       left_r, left_nxt;
  logic [31:0]       aleft_r, aleft_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              row_end_r, image_end_r, bad_r;

  logic              has_res, out_free, a_fire;
  logic [BYTE_W-1:0] nb_a, nb_b, nb_c, pred, recon;
  logic [BYTE_W:0]   avg_sum;

  assign has_res  = (a_op_r.kind != OP_CLEAR);
  assign out_free = !out_valid_r || out_ready;
  assign a_fire   = a_valid_r && (!has_res || out_free);
  assign take     = !a_valid_r || a_fire;

  always_comb begin
    nb_a    = left_r[{a_op_r.left_sel, 3'b000} +: BYTE_W];
    nb_c    = aleft_r[{a_op_r.left_sel, 3'b000} +: BYTE_W];
    nb_b    = a_op_r.zero_above ? '0 : above_data;
    avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (a_op_r.filt)
      FILT_NONE: pred = '0;
      FILT_SUB:  pred = nb_a;
      FILT_UP:   pred = nb_b;
      FILT_AVG:  pred = avg_sum[BYTE_W:1];
      default:   pred = paeth(nb_a, nb_b, nb_c);
    endcase
    recon = a_op_r.data + pred;
  end

  always_comb begin
    left_nxt  = left_r;
    aleft_nxt = aleft_r;
    if (a_fire) begin
      if (a_op_r.kind == OP_CLEAR) begin
        left_nxt  = '0;
        aleft_nxt = '0;
      end else if (a_op_r.kind == OP_SAMPLE) begin
        left_nxt  = {left_r[23:0], recon};
        aleft_nxt = {aleft_r[23:0], nb_b};
      end
    end
  end

  assign wr_en   = a_fire && (a_op_r.kind == OP_SAMPLE);
  assign wr_addr = a_idx_r;
  assign wr_data = recon;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      aleft_r     <= '0;
    end else begin
      left_r  <= left_nxt;
      aleft_r <= aleft_nxt;
      if (take) begin
        a_valid_r <= op_valid;
      end
      if (a_fire && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && op_valid) begin
      a_op_r  <= op;
      a_idx_r <= op_idx;
    end
    if (a_fire && has_res) begin
      if (a_op_r.kind == OP_ERROR) begin
        out_byte_r  <= '0;
        row_end_r   <= 1'b0;
        image_end_r <= 1'b0;
        bad_r       <= 1'b1;
      end else begin
        out_byte_r  <= recon;
        row_end_r   <= a_op_r.row_end;
        image_end_r <= a_op_r.image_end;
        bad_r       <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign row_end    = row_end_r;
  assign image_end  = image_end_r;
  assign bad_filter = bad_r;

endmodule

`default_nettype wire

>>> design/png_scanline_unfilter_unit.sv
// PNG scanline unfilter, 8-bit samples. An accepted byte is read from the line
// store with its op registered, then reconstructed into the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single line-store read port and each byte's reconstruct from the one before.
// Reset (synchronous, rst_n low) clears sequencer, histories and handshakes;
// the line store is not cleared. Depends on psu_pkg, psu_channels, psu_ram.
`default_nettype none

module png_scanline_unfilter_unit
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 16384
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psu_in_if.sink     in_chan,
  psu_out_if.source  out_chan,
  psu_cfg_if.sink    cfg_chan
);

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic              in_acc, take, op_valid;
  psu_op_t           op;
  logic [ADDR_W-1:0] op_idx, wr_addr;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_data, above_data;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = take;
  assign in_acc         = in_chan.valid && take;

  psu_ctrl #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_chan.valid),
    .cfg_addr (cfg_chan.addr),
    .cfg_data (cfg_chan.data),
    .in_acc   (in_acc),
    .in_byte  (in_chan.in_byte),
    .op_valid (op_valid),
    .op       (op),
    .op_idx   (op_idx)
  );

  psu_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_ROW_BYTES)) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (op_idx),
    .rdata (above_data)
  );

  psu_recon #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (op_valid),
    .op         (op),
    .op_idx     (op_idx),
    .above_data (above_data),
    .take       (take),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_byte   (out_chan.out_byte),
    .row_end    (out_chan.row_end),
    .image_end  (out_chan.image_end),
    .bad_filter (out_chan.bad_filter)
  );

endmodule

`default_nettype wire

>>> design/psu_checker.sv
// psu_checker: port-level checks on the unfilter unit, bound to the top level.
// Depends on psu_pkg and png_scanline_unfilter_unit.
`default_nettype none

module psu_checker
  import psu_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              row_end,
  input wire logic              image_end,
  input wire logic              bad_filter
);

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_filter |-> out_byte == '0 && !row_end && !image_end)
    else $error("error result carries data or end marks");

  a_image_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && image_end |-> row_end)
    else $error("image end without row end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(bad_filter))
    else $error("stalled result changed");

endmodule

bind png_scanline_unfilter_unit psu_checker u_psu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_byte   (out_chan.out_byte),
  .row_end    (out_chan.row_end),
  .image_end  (out_chan.image_end),
  .bad_filter (out_chan.bad_filter)
);

`default_nettype wire
